>>> rtl/drr_pkg.sv
// drr_pkg: shared constants, command/status structs and search helpers
// for the datagram reorder release block; no dependencies
package drr_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int MAX_RELEASE = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int REL_W       = $clog2(MAX_RELEASE + 1);
  localparam int SEQ_W       = 16;
  localparam int PAY_W       = 32;
  localparam int GRP_W       = 16;
  localparam int CNT_W       = 6;
  localparam int IN_W        = 48;
  localparam int OUT_W       = 64;

  localparam logic STATUS_RELEASE = 1'b0;
  localparam logic STATUS_DROP    = 1'b1;

  typedef struct packed {
    logic take_in;
    logic store;
    logic do_match;
    logic do_release;
    logic end_pass;
    logic push_last;
  } drr_cmd_t;

  typedef struct packed {
    logic pass_go;
    logic found;
    logic pend_valid;
    logic out_free;
  } drr_stat_t;

  // lowest index whose bit is clear
  function automatic logic [IDX_W-1:0] first_zero(input logic [STORE_DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int k = STORE_DEPTH - 1; k >= 0; k--) begin
      if (!v[k]) idx = IDX_W'(k);
    end
    return idx;
  endfunction

  // lowest index whose bit is set
  function automatic logic [IDX_W-1:0] first_one(input logic [STORE_DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int k = STORE_DEPTH - 1; k >= 0; k--) begin
      if (v[k]) idx = IDX_W'(k);
    end
    return idx;
  endfunction

endpackage

>>> rtl/drr_ctrl.sv
// drr_ctrl: sequencer for accept, store, match and release steps
// depends on drr_pkg
module drr_ctrl import drr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  drr_stat_t stat,
  output drr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_MATCH,
    S_EMIT,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = stat.pass_go ? S_MATCH : S_FLUSH;
      end
      S_MATCH: begin
        cmd.do_match = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.found) begin
          if (!stat.pend_valid || stat.out_free) begin
            cmd.do_release = 1'b1;
            state_next     = S_MATCH;
          end
        end else begin
          cmd.end_pass = 1'b1;
          state_next   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/drr_dp.sv
// drr_dp: datagram store, match vector, counters, pending and output registers
// depends on drr_pkg
module drr_dp import drr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast,
  output logic              m_tuser,
  input  drr_cmd_t          cmd,
  output drr_stat_t         stat
);

  logic [STORE_DEPTH-1:0] valid;
  logic [SEQ_W-1:0]       seq_mem [STORE_DEPTH];
  logic [PAY_W-1:0]       pay_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] match_vec;

  logic [SEQ_W-1:0] in_seq;
  logic [PAY_W-1:0] in_pay;
  logic             in_fin;

  logic [SEQ_W-1:0] next_expected;
  logic [GRP_W-1:0] group_count;
  logic [CNT_W-1:0] arrival_count;
  logic [CNT_W-1:0] batch_size;
  logic [REL_W-1:0] released;

  logic             pend_valid;
  logic             pend_status;
  logic [SEQ_W-1:0] pend_seq;
  logic [PAY_W-1:0] pend_pay;
  logic [GRP_W-1:0] pend_grp;

  logic             full;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] rel_idx;
  logic [CNT_W:0]   cnt;
  logic [CNT_W:0]   limit;
  logic             out_free;
  logic             push_now;
  logic [STORE_DEPTH-1:0] eq_vec;

  assign full     = &valid;
  assign free_idx = first_zero(valid);
  assign rel_idx  = first_one(match_vec);
  assign cnt      = {1'b0, arrival_count} + (CNT_W+1)'(1);
  assign limit    = (batch_size == '0) ? (CNT_W+1)'(1) : {1'b0, batch_size};
  assign out_free = !m_tvalid || m_tready;
  assign push_now = (cmd.do_release && pend_valid) || cmd.push_last;

  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      eq_vec[k] = valid[k] && (seq_mem[k] == next_expected);
    end
  end

  assign stat.pass_go    = (cnt >= limit) || in_fin;
  assign stat.found      = (|match_vec) && (released < REL_W'(MAX_RELEASE));
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      next_expected <= '0;
      group_count   <= '0;
      arrival_count <= '0;
      batch_size    <= CNT_W'(4);
      released      <= '0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wen) batch_size <= cfg_wdata;
      if (cmd.store) begin
        if (!full) begin
          valid[free_idx] <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
        if (stat.pass_go) begin
          arrival_count <= '0;
          released      <= '0;
        end else begin
          arrival_count <= cnt[CNT_W-1:0];
        end
      end
      if (cmd.do_release) begin
        valid[rel_idx] <= 1'b0;
        next_expected  <= next_expected + SEQ_W'(1);
        released       <= released + REL_W'(1);
        pend_valid     <= 1'b1;
      end
      if (cmd.end_pass && (released != '0)) begin
        group_count <= group_count + GRP_W'(1);
      end
      if (cmd.push_last) pend_valid <= 1'b0;
      if (push_now) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_seq <= s_tdata[SEQ_W-1:0];
      in_pay <= s_tdata[SEQ_W+PAY_W-1:SEQ_W];
      in_fin <= s_tlast;
    end
    if (cmd.store && !full) begin
      seq_mem[free_idx] <= in_seq;
      pay_mem[free_idx] <= in_pay;
    end
    if (cmd.do_match) match_vec <= eq_vec;
    if (cmd.store && full) begin
      pend_status <= STATUS_DROP;
      pend_seq    <= in_seq;
      pend_pay    <= in_pay;
      pend_grp    <= '0;
    end
    if (cmd.do_release) begin
      pend_status <= STATUS_RELEASE;
      pend_seq    <= seq_mem[rel_idx];
      pend_pay    <= pay_mem[rel_idx];
      pend_grp    <= group_count;
    end
    if (push_now) begin
      m_tdata <= {pend_grp, pend_pay, pend_seq};
      m_tuser <= pend_status;
      m_tlast <= cmd.push_last;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !push_now)
    else $error("result pushed over a beat still waiting");

  a_released_bound: assert property (@(posedge clk) disable iff (rst)
    released <= REL_W'(MAX_RELEASE))
    else $error("release count beyond run limit");

  a_store_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.store && !full) |-> !valid[free_idx])
    else $error("store into occupied slot");

  a_release_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.do_release |-> (valid[rel_idx] && seq_mem[rel_idx] == next_expected))
    else $error("released entry does not match expected sequence");
`endif

endmodule

>>> rtl/datagram_reorder_release.sv
// datagram_reorder_release: top level, joins the sequencer and the datapath
// depends on drr_pkg, drr_ctrl, drr_dp
//
// usage:
//   s_* carries arriving datagrams: tdata = seq number, payload; tlast = final.
//   m_* carries results: tdata = seq, payload, group; tuser = drop status;
//   tlast marks the last result caused by one arrival.
//   cfg_wen/cfg_wdata write batch_size; write only while the block is idle.
//   an arrival is taken when s_tready is high; the block then works on that
//   arrival alone: it accepts and stores it, then runs one match-vector step
//   and one release step per released datagram, then closes the pass with a
//   last match step and flushes the last result; an arrival that starts no
//   pass goes from store straight to the flush step. a pass releases at most
//   32 datagrams.
//   results go through a pending register and a one-beat output register;
//   when the receiver stalls, the sequencer holds until the output frees.
//   reset (rst, synchronous) clears all slot valid bits, counters and the
//   output valid; batch_size returns to 4. no clearing pass is needed.
module datagram_reorder_release import drr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // seq_number[15:0], payload[47:16]
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_seq[15:0], out_payload[47:16], group_index[63:48]
  output logic             m_tlast,
  output logic             m_tuser    // status
);

  drr_cmd_t  cmd;
  drr_stat_t stat;

  drr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  drr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
